[hdl/fsp_pkg.sv]
// Shared types, widths, register indexes and reset values of the flywheel speed controller.
package fsp_pkg;

	// Default gear ratio between flywheel and motor.
	localparam int GEAR_RATIO_DEF = 7;

	// Field widths.
	localparam int SPEED_W    = 11;
	localparam int AVG_W      = 12;
	localparam int ERR_W      = 13;
	localparam int DER_W      = 14;
	localparam int ESUM_W     = 32;
	localparam int TARGET_W   = 10;
	localparam int SETPOINT_W = 13;
	localparam int GAIN_W     = 16;
	localparam int THR_W      = 11;
	localparam int DRIVE_W    = 14;
	localparam int FDRIVE_W   = 15;

	// Arithmetic widths of the loop sum.
	localparam int SMALL_W  = 32;
	localparam int IPROD_W  = ESUM_W + GAIN_W + 1;
	localparam int SUM_W    = IPROD_W + 1;
	localparam int Q_SHIFT  = 9;

	// Stream and configuration port widths.
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 56;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;

	// Largest motor target.
	localparam logic [TARGET_W-1:0] TARGET_MAX = '1;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SETPOINT = 3'd0,
		REG_PROP     = 3'd1,
		REG_INTEG    = 3'd2,
		REG_DERIV    = 3'd3,
		REG_FEEDFWD  = 3'd4,
		REG_BANG     = 3'd5,
		REG_MAXDRV   = 3'd6
	} cfg_reg_t;

	// Register reset values.
	localparam logic [GAIN_W-1:0]  PROP_RST    = 16'd1818;
	localparam logic [GAIN_W-1:0]  INTEG_RST   = 16'd0;
	localparam logic [GAIN_W-1:0]  DERIV_RST   = 16'd640;
	localparam logic [GAIN_W-1:0]  FEEDFWD_RST = 16'd5632;
	localparam logic [THR_W-1:0]   BANG_RST    = 11'd15;
	localparam logic [DRIVE_W-1:0] MAXDRV_RST  = 14'd12000;

	// Register contents seen by the datapath; run_target is setpoint / gear ratio, saturated to TARGET_MAX.
	typedef struct packed {
		logic [TARGET_W-1:0] run_target;
		logic [GAIN_W-1:0]   prop;
		logic [GAIN_W-1:0]   integ;
		logic [GAIN_W-1:0]   deriv;
		logic [GAIN_W-1:0]   feedfwd;
		logic [THR_W-1:0]    bang_thr;
		logic [DRIVE_W-1:0]  max_drive;
	} cfg_t;

	// Loop stage results handed to the term stage.
	typedef struct packed {
		logic signed [ERR_W-1:0]  err;
		logic signed [DER_W-1:0]  der;
		logic signed [ESUM_W-1:0] esum;
		logic [TARGET_W-1:0]      target;
		logic signed [AVG_W-1:0]  avg;
		logic                     running;
		logic                     bang;
	} loop_s2_t;

	// Term stage results handed to the drive stage.
	typedef struct packed {
		logic signed [IPROD_W-1:0] iprod;
		logic signed [SMALL_W-1:0] small_sum;
		logic [TARGET_W-1:0]       target;
		logic signed [AVG_W-1:0]   avg;
		logic                      running;
		logic                      bang;
	} terms_s3_t;

endpackage

[hdl/fsp_cfg.sv]
// Configuration registers, with the motor target derived from the setpoint at write time.
module fsp_cfg import fsp_pkg::*; #(
	parameter int GEAR_RATIO = GEAR_RATIO_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	// Exact reciprocal for division by the gear ratio over the setpoint range.
	localparam int RL     = $clog2(GEAR_RATIO);
	localparam int RS     = SETPOINT_W + RL;
	localparam int RM_W   = RS + 1;
	localparam int PROD_W = SETPOINT_W + RM_W;
	localparam logic [RM_W-1:0] RECIP = RM_W'(((longint'(1) << RS) / GEAR_RATIO) + 1);

	logic [PROD_W-1:0]     recip_prod;
	logic [SETPOINT_W-1:0] quotient;
	logic [TARGET_W-1:0]   run_target_d;
	cfg_t                  cfg_q;

	// Divide the written setpoint and saturate to the target range.
	always_comb begin
		recip_prod = PROD_W'(cfg_data[SETPOINT_W-1:0]) * PROD_W'(RECIP);
		quotient   = recip_prod[RS +: SETPOINT_W];
		if (quotient > SETPOINT_W'(TARGET_MAX)) begin
			run_target_d = TARGET_MAX;
		end else begin
			run_target_d = quotient[TARGET_W-1:0];
		end
	end

	// Register writes; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.run_target <= '0;
			cfg_q.prop       <= PROP_RST;
			cfg_q.integ      <= INTEG_RST;
			cfg_q.deriv      <= DERIV_RST;
			cfg_q.feedfwd    <= FEEDFWD_RST;
			cfg_q.bang_thr   <= BANG_RST;
			cfg_q.max_drive  <= MAXDRV_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_SETPOINT: cfg_q.run_target <= run_target_d;
				REG_PROP:     cfg_q.prop       <= cfg_data[GAIN_W-1:0];
				REG_INTEG:    cfg_q.integ      <= cfg_data[GAIN_W-1:0];
				REG_DERIV:    cfg_q.deriv      <= cfg_data[GAIN_W-1:0];
				REG_FEEDFWD:  cfg_q.feedfwd    <= cfg_data[GAIN_W-1:0];
				REG_BANG:     cfg_q.bang_thr   <= cfg_data[THR_W-1:0];
				REG_MAXDRV:   cfg_q.max_drive  <= cfg_data[DRIVE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[hdl/fsp_loop.sv]
// Input register, run button logic, error terms and the controller state.
module fsp_loop import fsp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load_s1,
	input  logic                  load_s2,
	input  logic [IN_TDATA_W-1:0] in_data,
	input  cfg_t                  cfg,
	output loop_s2_t              s2
);

	logic signed [SPEED_W-1:0] front_s1, back_s1;
	logic                      btn_s1, key_s1;

	logic signed [ESUM_W-1:0] esum_q;
	logic signed [ERR_W-1:0]  prev_err_q;
	logic [TARGET_W-1:0]      target_q;
	logic                     press_q, toggle_q;

	logic [TARGET_W-1:0]      target_d;
	logic                     press_d, toggle_d, clr_sum;
	logic signed [AVG_W-1:0]  avg;
	logic signed [ERR_W-1:0]  err;
	logic signed [DER_W-1:0]  der;
	logic                     bang;
	logic signed [ESUM_W-1:0] esum_base, esum_sat, esum_d;
	logic signed [ESUM_W:0]   acc;
	loop_s2_t                 s2_d;
	loop_s2_t                 s2_q;

	// Input register.
	always_ff @(posedge clk) begin
		if (load_s1) begin
			front_s1 <= in_data[SPEED_W-1:0];
			back_s1  <= in_data[2*SPEED_W-1:SPEED_W];
			btn_s1   <= in_data[2*SPEED_W];
			key_s1   <= in_data[2*SPEED_W+1];
		end
	end

	// Button logic: toggle mode on press edges, hold-to-run otherwise.
	always_comb begin
		target_d = target_q;
		press_d  = press_q;
		toggle_d = toggle_q;
		clr_sum  = 1'b0;
		if (key_s1) begin
			if (btn_s1) begin
				if (!press_q) begin
					clr_sum  = 1'b1;
					target_d = toggle_q ? '0 : cfg.run_target;
					toggle_d = !toggle_q;
					press_d  = 1'b1;
				end
			end else begin
				press_d = 1'b0;
			end
		end else if (toggle_q) begin
			if (btn_s1) begin
				toggle_d = 1'b0;
			end
		end else if (btn_s1) begin
			if (!press_q) begin
				clr_sum  = 1'b1;
				target_d = cfg.run_target;
				press_d  = 1'b1;
			end
		end else begin
			clr_sum  = 1'b1;
			target_d = '0;
			press_d  = 1'b0;
		end
	end

	// Error, derivative and saturating integral in half-rpm units.
	always_comb begin
		avg  = $signed({front_s1[SPEED_W-1], front_s1}) + $signed({back_s1[SPEED_W-1], back_s1});
		err  = $signed({2'b00, target_d, 1'b0}) - $signed({avg[AVG_W-1], avg});
		der  = $signed({err[ERR_W-1], err}) - $signed({prev_err_q[ERR_W-1], prev_err_q});
		bang = err > $signed({1'b0, cfg.bang_thr, 1'b0});
		esum_base = clr_sum ? '0 : esum_q;
		acc = $signed({esum_base[ESUM_W-1], esum_base})
			+ $signed({{(ESUM_W+1-ERR_W){err[ERR_W-1]}}, err});
		if (acc[ESUM_W] != acc[ESUM_W-1]) begin
			esum_sat = acc[ESUM_W] ? {1'b1, {(ESUM_W-1){1'b0}}} : {1'b0, {(ESUM_W-1){1'b1}}};
		end else begin
			esum_sat = acc[ESUM_W-1:0];
		end
		esum_d = bang ? esum_base : esum_sat;

		s2_d.err     = err;
		s2_d.der     = der;
		s2_d.esum    = esum_d;
		s2_d.target  = target_d;
		s2_d.avg     = avg;
		s2_d.running = toggle_d;
		s2_d.bang    = bang;
	end

	// Controller state advances with each item leaving the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esum_q     <= '0;
			prev_err_q <= '0;
			target_q   <= '0;
			press_q    <= 1'b0;
			toggle_q   <= 1'b0;
		end else if (load_s2) begin
			esum_q     <= esum_d;
			prev_err_q <= err;
			target_q   <= target_d;
			press_q    <= press_d;
			toggle_q   <= toggle_d;
		end
	end

	// Stage two register.
	always_ff @(posedge clk) begin
		if (load_s2) begin
			s2_q <= s2_d;
		end
	end

	assign s2 = s2_q;

`ifndef NO_ASSERTIONS
	// The controller state only moves when an item advances.
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!load_s2 |=> $stable(esum_q) && $stable(target_q) && $stable(toggle_q))
		else $error("controller state changed without an advancing item");

	// A target change always comes with a cleared integral.
	a_target_clr: assert property (@(posedge clk) disable iff (!arst_n)
		(target_d != target_q) |-> clr_sum)
		else $error("target changed without clearing the integral");
`endif

endmodule

[hdl/fsp_terms.sv]
// Gain products of the PID and feedforward terms.
module fsp_terms import fsp_pkg::*; (
	input  logic      clk,
	input  logic      load_s3,
	input  loop_s2_t  s2,
	input  cfg_t      cfg,
	output terms_s3_t s3
);

	logic signed [IPROD_W-1:0] iprod;
	logic signed [SMALL_W-1:0] pterm, dterm, fterm;
	terms_s3_t                 s3_q;

	// Integral product is the wide one; the other three are narrow and summed here.
	always_comb begin
		iprod = s2.esum * $signed({1'b0, cfg.integ});
		pterm = s2.err * $signed({1'b0, cfg.prop});
		dterm = s2.der * $signed({1'b0, cfg.deriv});
		fterm = $signed({1'b0, s2.target, 1'b0}) * $signed({1'b0, cfg.feedfwd});
	end

	// Stage three register.
	always_ff @(posedge clk) begin
		if (load_s3) begin
			s3_q.iprod     <= iprod;
			s3_q.small_sum <= pterm + dterm + fterm;
			s3_q.target    <= s2.target;
			s3_q.avg       <= s2.avg;
			s3_q.running   <= s2.running;
			s3_q.bang      <= s2.bang;
		end
	end

	assign s3 = s3_q;

endmodule

[hdl/fsp_drive.sv]
// Final sum, scaling and clamping of the drive, and the output register.
module fsp_drive import fsp_pkg::*; (
	input  logic                        clk,
	input  logic                        load_out,
	input  terms_s3_t                   s3,
	input  cfg_t                        cfg,
	output logic [DRIVE_W-1:0]          back_drive,
	output logic signed [FDRIVE_W-1:0]  front_drive,
	output logic signed [AVG_W-1:0]     speed_avg,
	output logic [TARGET_W-1:0]         target_speed,
	output logic                        running
);

	logic signed [SUM_W-1:0]     sum;
	logic [SUM_W-Q_SHIFT-1:0]    scaled;
	logic [DRIVE_W-1:0]          drive;

	logic [DRIVE_W-1:0]          back_q;
	logic signed [FDRIVE_W-1:0]  front_q;
	logic signed [AVG_W-1:0]     avg_q;
	logic [TARGET_W-1:0]         target_q;
	logic                        running_q;

	// Sum the terms and map the Q9 result into 0..max_drive.
	always_comb begin
		sum = $signed({s3.iprod[IPROD_W-1], s3.iprod})
			+ $signed({{(SUM_W-SMALL_W){s3.small_sum[SMALL_W-1]}}, s3.small_sum});
		scaled = sum[SUM_W-1:Q_SHIFT];
		if (s3.bang) begin
			drive = cfg.max_drive;
		end else if (sum[SUM_W-1] || (sum == '0)) begin
			drive = '0;
		end else if (scaled > (SUM_W-Q_SHIFT)'(cfg.max_drive)) begin
			drive = cfg.max_drive;
		end else begin
			drive = scaled[DRIVE_W-1:0];
		end
		if (s3.target == '0) begin
			drive = '0;
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (load_out) begin
			back_q    <= drive;
			front_q   <= -$signed({1'b0, drive});
			avg_q     <= s3.avg;
			target_q  <= s3.target;
			running_q <= s3.running;
		end
	end

	assign back_drive   = back_q;
	assign front_drive  = front_q;
	assign speed_avg    = avg_q;
	assign target_speed = target_q;
	assign running      = running_q;

endmodule

[hdl/flywheel_speed_pid_with_toggle.sv]
// Top level of the flywheel speed controller: stream handshake and pipeline.
//
// Each input transfer is one control tick: two measured motor speeds, the
// run button level and the mode key. Each tick gives exactly one result
// transfer with the back and front drive, the averaged speed, the motor
// target and the toggle run flag.
// The configuration port writes one register per cycle with cfg_we high;
// writes must be made only while no tick is in flight; the block itself
// does not enforce this. The pipeline takes one tick per cycle while the
// receiver does not stall. The pipeline has an input register, the loop
// stage that updates the controller state, the gain product stage and the
// output register; the controller state is carried from one tick to the
// next within the single loop stage.
// When the receiver stalls, the output register holds its result and the
// earlier stages keep filling until all of them are full; s_tready then
// drops. Reset clears the pipeline, the controller state and sets the
// registers to their defaults.
module flywheel_speed_pid_with_toggle import fsp_pkg::*; #(
	parameter int GEAR_RATIO = GEAR_RATIO_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// Input stream.
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // front_speed, back_speed, button, mode_key
	// Result stream.
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // back_drive, front_drive, speed_avg,
	                                         // target_speed, running, zero fill
	// Configuration write port.
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t      cfg;
	loop_s2_t  s2;
	terms_s3_t s3;

	logic valid_s1, valid_s2, valid_s3, out_valid_q;
	logic en_s2, en_s3, en_out;

	logic [DRIVE_W-1:0]         back_drive;
	logic signed [FDRIVE_W-1:0] front_drive;
	logic signed [AVG_W-1:0]    speed_avg;
	logic [TARGET_W-1:0]        target_speed;
	logic                       running;

	// A stage may take new data when it is empty or its content moves on.
	assign en_out   = !out_valid_q || m_tready;
	assign en_s3    = !valid_s3 || en_out;
	assign en_s2    = !valid_s2 || en_s3;
	assign s_tready = !valid_s1 || en_s2;

	// Valid bits of the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (en_s3) begin
				valid_s3 <= valid_s2;
			end
			if (en_out) begin
				out_valid_q <= valid_s3;
			end
		end
	end

	fsp_cfg #(
		.GEAR_RATIO(GEAR_RATIO)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	fsp_loop u_loop (
		.clk    (clk),
		.arst_n (arst_n),
		.load_s1(s_tvalid && s_tready),
		.load_s2(valid_s1 && en_s2),
		.in_data(s_tdata),
		.cfg    (cfg),
		.s2     (s2)
	);

	fsp_terms u_terms (
		.clk    (clk),
		.load_s3(valid_s2 && en_s3),
		.s2     (s2),
		.cfg    (cfg),
		.s3     (s3)
	);

	fsp_drive u_drive (
		.clk         (clk),
		.load_out    (valid_s3 && en_out),
		.s3          (s3),
		.cfg         (cfg),
		.back_drive  (back_drive),
		.front_drive (front_drive),
		.speed_avg   (speed_avg),
		.target_speed(target_speed),
		.running     (running)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(OUT_TDATA_W-DRIVE_W-FDRIVE_W-AVG_W-TARGET_W-1)'(0),
		running, target_speed, speed_avg, front_drive, back_drive};

`ifndef NO_ASSERTIONS
	// A zero target never drives the motors.
	a_zero_target: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (target_speed == '0) |-> (back_drive == '0))
		else $error("drive present with zero target");

	// Front drive mirrors the back drive.
	a_front_mirror: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (front_drive == -$signed({1'b0, back_drive})))
		else $error("front drive is not the negated back drive");

	// Input is refused only when every stage is full and the output is stalled.
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && valid_s2 && valid_s3 && out_valid_q && !m_tready)
		else $error("input refused while the pipeline had room");
`endif

endmodule
